// ===== sv/csacc_pkg.sv =====
`default_nettype none
package csacc_pkg;

    // Fixed field widths of the command and result beats
    localparam int ADDR_W = 32;

    // Access kinds
    localparam logic [1:0] CMD_LOAD      = 2'd0;
    localparam logic [1:0] CMD_STORE     = 2'd1;
    localparam logic [1:0] CMD_SNP_LOAD  = 2'd2;
    localparam logic [1:0] CMD_SNP_STORE = 2'd3;

    // Coherence modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_VI     = 2'd1;
    localparam logic [1:0] MODE_MSI    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Line state codes
    localparam logic [1:0] LS_INV    = 2'd0;
    localparam logic [1:0] LS_VALID  = 2'd1;
    localparam logic [1:0] LS_SHARED = 2'd2;
    localparam logic [1:0] LS_MOD    = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic       writeback;
        logic       upgraded;
        logic [1:0] way_used;
    } t_rsp;

    typedef enum logic {
        FSM_IDLE,
        FSM_LOOKUP
    } t_fsm;

endpackage
`default_nettype wire

// ===== sv/csacc_ram.sv =====
`default_nettype none
module csacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/csacc_update.sv =====
`default_nettype none
module csacc_update
    import csacc_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int TAG_W = 22,
    parameter int WAY_W = 2
) (
    input  wire logic [WAYS*(TAG_W+3)+WAY_W-1:0] i_row,
    input  wire logic                            i_row_vld,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic [TAG_W-1:0]                i_tag,
    output logic      [WAYS*(TAG_W+3)+WAY_W-1:0] o_row,
    output t_rsp                                 o_rsp
);

    localparam int LINE_W = TAG_W + 3;
    localparam int PTR_LSB = WAYS * LINE_W;

    logic [WAYS*LINE_W+WAY_W-1:0] row_old;
    logic [TAG_W-1:0] tags   [WAYS];
    logic [1:0]       sts    [WAYS];
    logic             dtys   [WAYS];
    logic [TAG_W-1:0] n_tags [WAYS];
    logic [1:0]       n_sts  [WAYS];
    logic             n_dtys [WAYS];
    logic [WAY_W-1:0] ptr;
    logic [WAY_W-1:0] ptr_inc;
    logic [WAY_W-1:0] n_ptr;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] way;
    logic             found;
    logic             proc;
    logic             store;
    logic [1:0]       st_sel;
    logic             dty_sel;
    logic             hit;
    logic             wb;
    logic             upg;

    // Unwritten sets read as the reset image: all zero tags, invalid, clean
    assign row_old = i_row_vld ? i_row : '0;
    assign ptr     = row_old[PTR_LSB +: WAY_W];
    assign ptr_inc = (32'(ptr) == WAYS - 1) ? '0 : WAY_W'(32'(ptr) + 1);
    assign proc    = (i_cmd == CMD_LOAD) || (i_cmd == CMD_STORE);
    assign store   = (i_cmd == CMD_STORE);

    // Unpack the set row into per-way fields
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tags[w] = row_old[w*LINE_W +: TAG_W];
            sts[w]  = row_old[w*LINE_W + TAG_W +: 2];
            dtys[w] = row_old[w*LINE_W + TAG_W + 2];
        end
    end

    // Compare all ways in parallel; lowest matching way wins
    always_comb begin
        logic ok;
        found   = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            ok = (tags[w] == i_tag);
            case (i_mode)
                MODE_NONE:   ok = ok;
                MODE_VI:     ok = ok && (sts[w] == LS_VALID);
                MODE_MSI:    ok = ok && ((sts[w] == LS_SHARED) || (sts[w] == LS_MOD));
                default:     ok = 1'b0;
            endcase
            if (ok) begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    assign way     = found ? hit_way : ptr;
    assign st_sel  = sts[way];
    assign dty_sel = dtys[way];

    // Modify the selected line and the victim pointer
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_tags[w] = tags[w];
            n_sts[w]  = sts[w];
            n_dtys[w] = dtys[w];
        end
        n_ptr = ptr;
        hit   = 1'b0;
        wb    = 1'b0;
        upg   = 1'b0;
        if (i_mode == MODE_UNUSED) begin
            // ignore the access
        end else if (proc) begin
            if (found && !((i_mode == MODE_MSI) && store && (st_sel == LS_SHARED))) begin
                hit = 1'b1;
                if (store) begin
                    n_dtys[way] = 1'b1;
                end
                n_ptr = (32'(way) == WAYS - 1) ? '0 : WAY_W'(32'(way) + 1);
            end else if (found) begin
                // upgrade a shared line to modified
                upg         = 1'b1;
                wb          = dty_sel;
                n_dtys[way] = 1'b1;
                n_sts[way]  = LS_MOD;
                n_ptr       = ptr_inc;
            end else begin
                // replace the victim line
                wb          = dty_sel;
                n_tags[way] = i_tag;
                n_dtys[way] = store;
                if (i_mode == MODE_VI) begin
                    n_sts[way] = LS_VALID;
                end else if (i_mode == MODE_MSI) begin
                    n_sts[way] = store ? LS_MOD : LS_SHARED;
                end
                n_ptr = ptr_inc;
            end
        end else if (i_mode == MODE_NONE) begin
            hit = found;
        end else if (found) begin
            hit = 1'b1;
            if (!((i_mode == MODE_MSI) && (i_cmd == CMD_SNP_LOAD) && (st_sel == LS_SHARED))) begin
                wb          = dty_sel;
                n_dtys[way] = 1'b0;
                n_sts[way]  = ((i_mode == MODE_MSI) && (i_cmd == CMD_SNP_LOAD)) ?
                              LS_SHARED : LS_INV;
            end
        end
    end

    // Repack the row for write-back
    always_comb begin
        o_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            o_row[w*LINE_W +: LINE_W] = {n_dtys[w], n_sts[w], n_tags[w]};
        end
        o_row[PTR_LSB +: WAY_W] = n_ptr;
    end

    assign o_rsp.hit       = hit;
    assign o_rsp.writeback = wb;
    assign o_rsp.upgraded  = upg;
    assign o_rsp.way_used  = 2'(way);

endmodule
`default_nettype wire

// ===== sv/coherent_set_assoc_cache_ctrl.sv =====
// Channel   | Signals                     | Beat taken when
// ----------+-----------------------------+-------------------------
// command   | start, busy, i_req          | start & !busy
// result    | o_valid, o_rsp              | o_valid (one cycle, no stall)
// config    | i_cfg_we, i_cfg_wdata       | i_cfg_we
//
// Each access first reads the set row from the tag RAM, then in the
// lookup compares all ways, modifies the row and writes it back. busy is
// high during the lookup, so no new access is taken until the write-back.
// The result beat appears the cycle after the write-back, alongside the
// read of the next access. Reset clears one valid flag per set; a set not
// yet written reads as all invalid with a zero victim pointer, so no
// clearing pass is needed. The result receiver cannot stall.
`default_nettype none
module coherent_set_assoc_cache_ctrl
    import csacc_pkg::*;
#(
    parameter int ADDR_BITS   = 32,
    parameter int OFFSET_BITS = 4,
    parameter int INDEX_BITS  = 6,
    parameter int WAYS        = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_req       i_req,
    output logic            o_valid,
    output t_rsp            o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata
);

    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int SET_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W   = TAG_W + 3;
    localparam int ROW_W    = WAYS * LINE_W + WAY_W;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? ~64'd0 : ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [63:0] TAG_MASK =
        (TAG_BITS <= 0) ? 64'd0 : ((64'd1 << TAG_BITS) - 64'd1);
    localparam logic [63:0] SET_MASK = 64'(NUM_SETS - 1);

    t_fsm              r_fsm, n_fsm;
    t_req              r_req;
    logic [1:0]        r_mode;
    logic [NUM_SETS-1:0] r_set_vld;
    logic              r_row_vld;
    logic              r_valid;
    t_rsp              r_rsp;
    logic [63:0]       addr_in;
    logic [63:0]       addr_cur;
    logic [SET_W-1:0]  set_in;
    logic [SET_W-1:0]  set_cur;
    logic [TAG_W-1:0]  tag_cur;
    logic              ram_re;
    logic              ram_we;
    logic [ROW_W-1:0]  ram_rdata;
    logic [ROW_W-1:0]  row_new;
    t_rsp              rsp_new;

    // Split addresses into set index and tag
    assign addr_in  = 64'(i_req.addr) & ADDR_MASK;
    assign addr_cur = 64'(r_req.addr) & ADDR_MASK;
    assign set_in   = SET_W'((addr_in >> OFFSET_BITS) & SET_MASK);
    assign set_cur  = SET_W'((addr_cur >> OFFSET_BITS) & SET_MASK);
    assign tag_cur  = TAG_W'((addr_cur >> (OFFSET_BITS + INDEX_BITS)) & TAG_MASK);

    // Sequence read then modify/write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_comb begin
        n_fsm  = r_fsm;
        busy   = 1'b0;
        ram_re = 1'b0;
        ram_we = 1'b0;
        unique case (r_fsm)
            FSM_IDLE: begin
                if (start) begin
                    ram_re = 1'b1;
                    n_fsm  = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP: begin
                busy   = 1'b1;
                ram_we = 1'b1;
                n_fsm  = FSM_IDLE;
            end
            default: begin
                n_fsm = FSM_IDLE;
            end
        endcase
    end

    // Hold the command beat for the lookup cycle
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_req     <= i_req;
            r_row_vld <= r_set_vld[set_in];
        end
    end

    // Mark sets as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_vld <= '0;
        end else if (ram_we) begin
            r_set_vld[set_cur] <= 1'b1;
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    csacc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (set_cur),
        .i_wdata (row_new),
        .i_re    (ram_re),
        .i_raddr (set_in),
        .o_rdata (ram_rdata)
    );

    csacc_update #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_update (
        .i_row     (ram_rdata),
        .i_row_vld (r_row_vld),
        .i_mode    (r_mode),
        .i_cmd     (r_req.cmd),
        .i_tag     (tag_cur),
        .o_row     (row_new),
        .o_rsp     (rsp_new)
    );

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_rsp <= rsp_new;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire
